[src/b64d_pkg.sv]
package b64d_pkg;

  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_PAD   = 8'h3D;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UZ    = 8'h5A;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LZ    = 8'h7A;
  localparam logic [7:0] CHR_D0    = 8'h30;
  localparam logic [7:0] CHR_D9    = 8'h39;

  localparam logic [6:0] NOT_B64 = 7'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // one decoded group (or one error) waiting for the output side
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        bad;
  } b64d_job_t;

  typedef struct packed {
    logic      valid;
    b64d_job_t job;
  } b64d_req_t;

  // bit 6 set: not an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] v;
    d = 8'd0;
    v = NOT_B64;
    if (c >= CHR_UA && c <= CHR_UZ) begin
      d = c - CHR_UA;
      v = d[6:0];
    end else if (c >= CHR_LA && c <= CHR_LZ) begin
      d = c - CHR_LA + 8'd26;
      v = d[6:0];
    end else if (c >= CHR_D0 && c <= CHR_D9) begin
      d = c - CHR_D0 + 8'd52;
      v = d[6:0];
    end else if (c == CHR_PLUS) begin
      v = 7'd62;
    end else if (c == CHR_SLASH) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

[src/b64d_front.sv]
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  output b64d_req_t  push
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pad_r, pad_nxt;

  logic [6:0]  sext;
  logic        is_nl, is_pad, ok;

  always_comb begin
    sext   = sextet_of(char_in);
    is_nl  = (char_in == CHR_NL);
    is_pad = (char_in == CHR_PAD);
    ok     = (!sext[6] && !pad_r) || (is_pad && cnt_r >= 2'd2);

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    push    = '0;

    if (accept && !is_nl) begin
      if (!ok) begin
        acc_nxt         = '0;
        cnt_nxt         = '0;
        pad_nxt         = 1'b0;
        push.valid      = 1'b1;
        push.job.word   = '0;
        push.job.nbytes = 2'd1;
        push.job.bad    = 1'b1;
      end else if (!is_pad) begin
        if (cnt_r != 2'd3) begin
          acc_nxt = {acc_r[11:0], sext[5:0]};
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt         = '0;
          cnt_nxt         = '0;
          pad_nxt         = 1'b0;
          push.valid      = 1'b1;
          push.job.word   = {acc_r, sext[5:0]};
          push.job.nbytes = 2'd3;
        end
      end else if (cnt_r == 2'd2) begin
        acc_nxt = {acc_r[11:0], 6'd0};
        cnt_nxt = 2'd3;
        pad_nxt = 1'b1;
      end else begin
        acc_nxt         = '0;
        cnt_nxt         = '0;
        pad_nxt         = 1'b0;
        push.valid      = 1'b1;
        push.job.word   = {acc_r, 6'd0};
        push.job.nbytes = pad_r ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      pad_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

  // pad only ever set with the group at its last place
  a_pad_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r |-> cnt_r == 2'd3)
    else $error("pad set outside last place");

endmodule

[src/b64d_queue.sv]
module b64d_queue
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  b64d_req_t push,
  input  logic      pop,
  output b64d_req_t head,
  output logic      full
);

  b64d_job_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push.valid && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push.valid) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && full))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

[src/b64d_back.sv]
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64d_req_t  head,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_bad_char,
  output logic       out_group_end
);

  logic [1:0] k_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bad_r, end_r;

  logic       load, last;
  logic [7:0] sel_byte;

  always_comb begin
    load = head.valid && (!valid_r || !out_stall);
    last = (k_r == head.job.nbytes - 2'd1);
    pop  = load && last;
    case (k_r)
      2'd0:    sel_byte = head.job.word[23:16];
      2'd1:    sel_byte = head.job.word[15:8];
      default: sel_byte = head.job.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        k_r     <= last ? 2'd0 : k_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.job.bad ? 8'd0 : sel_byte;
      bad_r  <= head.job.bad;
      end_r  <= last;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_bad_char  = bad_r;
  assign out_group_end = end_r;

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && bad_r) |-> (byte_r == 8'd0 && end_r))
    else $error("error result not single zero byte");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> k_r < head.job.nbytes)
    else $error("byte index past group length");

endmodule

[src/base64_stream_decoder.sv]
// Streaming base64 decoder. Takes one character per cycle on the in_ channel and
// returns decoded bytes on the out_ channel, one per cycle unless out_stall holds
// them, most significant byte of each group first, with out_group_end on the last
// byte caused by a character. Newlines are dropped; '=' padding ends a group with
// two or one bytes; any other character outside the alphabet (or misplaced padding)
// gives one result with out_bad_char set and out_byte zero, and restarts the group.
// Character decode and group tracking happen in the accept cycle; finished groups
// wait in a four-entry queue and leave through a registered output stage. With the
// queue empty, the first byte of a group passes through the queue entry and then the
// output register after the closing character is accepted; bytes of earlier groups
// still queued or stalled come out first. The input takes a character every cycle
// unless the queue is full; sustained rate is bounded by the output port at one byte
// per cycle, i.e. three bytes per four characters keeps pace.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_bad_char,
  output logic       out_group_end
);

  b64d_req_t push, head;
  logic      full, pop, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  b64d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .char_in (in_char_in),
    .push    (push)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_bad_char  (out_bad_char),
    .out_group_end (out_group_end)
  );

endmodule
